// ===== sv/msm_pkg.sv =====
// msm_pkg: types and constants shared by the control surface mapper modules
// no dependencies

package msm_pkg;

    localparam int SlotCount = 5;
    localparam int SlotW     = 3;

    localparam logic [1:0] EV_BUTTON   = 2'd0;
    localparam logic [1:0] EV_ENCODER  = 2'd1;
    localparam logic [1:0] EV_ABSOLUTE = 2'd2;

    localparam logic [1:0] FULL_LENGTH = 2'd3;

    localparam logic [7:0] ST_NOTE_DECK1 = 8'h90;
    localparam logic [7:0] ST_NOTE_DECK2 = 8'h91;
    localparam logic [7:0] ST_NOTE_GLOB  = 8'h96;
    localparam logic [7:0] ST_CC_DECK1   = 8'hB0;
    localparam logic [7:0] ST_CC_DECK2   = 8'hB1;
    localparam logic [7:0] ST_CC_MASTER  = 8'hB6;

    localparam logic [7:0] NOTE_PLAY     = 8'h0B;
    localparam logic [7:0] NOTE_CUE      = 8'h0C;
    localparam logic [7:0] NOTE_JOGTOUCH = 8'h36;
    localparam logic [7:0] NOTE_PFL      = 8'h54;
    localparam logic [7:0] NOTE_LOAD1    = 8'h46;
    localparam logic [7:0] NOTE_LOAD2    = 8'h47;

    localparam logic [7:0] CC_JOG_SCRATCH = 8'h22;
    localparam logic [7:0] CC_JOG_BEND    = 8'h23;
    localparam logic [7:0] CC_SIDE_BEND   = 8'h21;
    localparam logic [7:0] CC_TEMPO_MSB   = 8'h00;
    localparam logic [7:0] CC_TEMPO_LSB   = 8'h20;
    localparam logic [7:0] CC_VOL_MSB     = 8'h13;
    localparam logic [7:0] CC_VOL_LSB     = 8'h33;
    localparam logic [7:0] CC_BROWSE      = 8'h40;
    localparam logic [7:0] CC_XFADE_MSB   = 8'h1F;
    localparam logic [7:0] CC_XFADE_LSB   = 8'h3F;

    localparam logic [7:0] ENC_CENTER = 8'd64;

    localparam logic [4:0] CTL_PLAY      = 5'd0;
    localparam logic [4:0] CTL_CUE       = 5'd2;
    localparam logic [4:0] CTL_JOGTOUCH  = 5'd4;
    localparam logic [4:0] CTL_PFL       = 5'd6;
    localparam logic [4:0] CTL_LOAD1     = 5'd8;
    localparam logic [4:0] CTL_LOAD2     = 5'd9;
    localparam logic [4:0] CTL_SCRATCH   = 5'd10;
    localparam logic [4:0] CTL_BEND      = 5'd12;
    localparam logic [4:0] CTL_TEMPO     = 5'd14;
    localparam logic [4:0] CTL_VOLUME    = 5'd16;
    localparam logic [4:0] CTL_BROWSE    = 5'd18;
    localparam logic [4:0] CTL_XFADE     = 5'd19;

    localparam logic [SlotW-1:0] SLOT_TEMPO  = 3'd0;
    localparam logic [SlotW-1:0] SLOT_VOLUME = 3'd2;
    localparam logic [SlotW-1:0] SLOT_XFADE  = 3'd4;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_BUTTON,
        OP_ENCODER,
        OP_HALF
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [4:0]       control;
        logic [SlotW-1:0] slot;
        logic             high_half;
    } decode_t;

endpackage

// ===== sv/msm_decode.sv =====
// msm_decode: classifies one MIDI message into an operation and a control id
// depends on msm_pkg

module msm_decode
    import msm_pkg::*;
(
    input  logic [1:0] message_length,
    input  logic [7:0] status_byte,
    input  logic [7:0] first_data,
    output decode_t    dec
);

    logic       deck;
    logic [4:0] deck_ext;
    logic [2:0] deck_slot;

    assign deck      = status_byte[0];
    assign deck_ext  = {4'd0, deck};
    assign deck_slot = {2'd0, deck};

    always_comb
    begin
        dec.op        = OP_NONE;
        dec.control   = '0;
        dec.slot      = '0;
        dec.high_half = 1'b0;
        if (message_length == FULL_LENGTH)
        begin
            case (status_byte)
                ST_NOTE_DECK1, ST_NOTE_DECK2:
                begin
                    dec.op = OP_BUTTON;
                    case (first_data)
                        NOTE_PLAY:     dec.control = CTL_PLAY + deck_ext;
                        NOTE_CUE:      dec.control = CTL_CUE + deck_ext;
                        NOTE_JOGTOUCH: dec.control = CTL_JOGTOUCH + deck_ext;
                        NOTE_PFL:      dec.control = CTL_PFL + deck_ext;
                        default:       dec.op = OP_NONE;
                    endcase
                end
                ST_NOTE_GLOB:
                begin
                    dec.op = OP_BUTTON;
                    case (first_data)
                        NOTE_LOAD1: dec.control = CTL_LOAD1;
                        NOTE_LOAD2: dec.control = CTL_LOAD2;
                        default:    dec.op = OP_NONE;
                    endcase
                end
                ST_CC_DECK1, ST_CC_DECK2:
                begin
                    case (first_data)
                        CC_JOG_SCRATCH:
                        begin
                            dec.op      = OP_ENCODER;
                            dec.control = CTL_SCRATCH + deck_ext;
                        end
                        CC_JOG_BEND, CC_SIDE_BEND:
                        begin
                            dec.op      = OP_ENCODER;
                            dec.control = CTL_BEND + deck_ext;
                        end
                        CC_TEMPO_MSB, CC_TEMPO_LSB:
                        begin
                            dec.op        = OP_HALF;
                            dec.control   = CTL_TEMPO + deck_ext;
                            dec.slot      = SLOT_TEMPO + deck_slot;
                            dec.high_half = (first_data == CC_TEMPO_MSB);
                        end
                        CC_VOL_MSB, CC_VOL_LSB:
                        begin
                            dec.op        = OP_HALF;
                            dec.control   = CTL_VOLUME + deck_ext;
                            dec.slot      = SLOT_VOLUME + deck_slot;
                            dec.high_half = (first_data == CC_VOL_MSB);
                        end
                        default: dec.op = OP_NONE;
                    endcase
                end
                ST_CC_MASTER:
                begin
                    case (first_data)
                        CC_BROWSE:
                        begin
                            dec.op      = OP_ENCODER;
                            dec.control = CTL_BROWSE;
                        end
                        CC_XFADE_MSB, CC_XFADE_LSB:
                        begin
                            dec.op        = OP_HALF;
                            dec.control   = CTL_XFADE;
                            dec.slot      = SLOT_XFADE;
                            dec.high_half = (first_data == CC_XFADE_MSB);
                        end
                        default: dec.op = OP_NONE;
                    endcase
                end
                default: dec.op = OP_NONE;
            endcase
        end
    end

endmodule

// ===== sv/msm_slots.sv =====
// msm_slots: five 14-bit value slots built from separately received halves
// depends on msm_pkg

module msm_slots
    import msm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [SlotW-1:0] slot,
    input  logic             high_half,
    input  logic [6:0]       data,
    output logic             complete,
    output logic [13:0]      value
);

    logic [6:0]           high_store_reg [SlotCount];
    logic [6:0]           low_store_reg  [SlotCount];
    logic [SlotCount-1:0] high_seen_reg;
    logic [SlotCount-1:0] low_seen_reg;
    logic [SlotCount-1:0] high_seen_next;
    logic [SlotCount-1:0] low_seen_next;

    // combined value including the half arriving now
    always_comb
    begin
        if (high_half)
        begin
            complete = low_seen_reg[slot];
            value    = {data, low_store_reg[slot]};
        end
        else
        begin
            complete = high_seen_reg[slot];
            value    = {high_store_reg[slot], data};
        end
    end

    always_comb
    begin
        high_seen_next = high_seen_reg;
        low_seen_next  = low_seen_reg;
        if (wr_en)
        begin
            if (high_half)
                high_seen_next[slot] = 1'b1;
            else
                low_seen_next[slot] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_seen_reg <= '0;
            low_seen_reg  <= '0;
        end
        else
        begin
            high_seen_reg <= high_seen_next;
            low_seen_reg  <= low_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (high_half)
                high_store_reg[slot] <= data;
            else
                low_store_reg[slot] <= data;
        end
    end

endmodule

// ===== sv/midi_control_surface_mapper_core.sv =====
// midi_control_surface_mapper_core: top level of the control surface mapper
// depends on msm_pkg, msm_decode, msm_slots

// Each accepted MIDI message is captured in an input register, decoded
// combinationally and, if it gives a result, written to a result
// register: a button event, a signed encoder delta or a 14-bit absolute
// value from one of five MSB/LSB slots. One message is taken per cycle
// while the input stage is not stalled. Messages that give no result
// still pass through the input register; MSB/LSB halves update the slots.
// The input stage stalls only while a result waits in the output register.

module midi_control_surface_mapper_core
    import msm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         message_length,
    input  logic [7:0]         status_byte,
    input  logic [7:0]         first_data,
    input  logic [7:0]         second_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         event_type,
    output logic [4:0]         control_number,
    output logic signed [14:0] event_value
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [1:0]  s1_length_reg;
    logic [7:0]  s1_status_reg;
    logic [7:0]  s1_first_reg;
    logic [7:0]  s1_second_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  out_type_reg;
    logic [1:0]  out_type_next;
    logic [4:0]  out_control_reg;
    logic [4:0]  out_control_next;
    logic [14:0] out_value_reg;
    logic [14:0] out_value_next;

    decode_t     dec;
    logic        out_free;
    logic        s1_go;
    logic        result_hit;
    logic        slot_complete;
    logic [13:0] slot_value;
    logic        take_in;

    msm_decode u_decode (
        .message_length (s1_length_reg),
        .status_byte    (s1_status_reg),
        .first_data     (s1_first_reg),
        .dec            (dec)
    );

    msm_slots u_slots (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (s1_go && (dec.op == OP_HALF)),
        .slot      (dec.slot),
        .high_half (dec.high_half),
        .data      (s1_second_reg[6:0]),
        .complete  (slot_complete),
        .value     (slot_value)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign s1_go    = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || s1_go;
    assign take_in  = in_valid && in_ready;

    always_comb
    begin
        result_hit       = 1'b0;
        out_type_next    = EV_BUTTON;
        out_control_next = dec.control;
        out_value_next   = '0;
        case (dec.op)
            OP_BUTTON:
            begin
                result_hit     = 1'b1;
                out_type_next  = EV_BUTTON;
                out_value_next = {14'd0, (s1_second_reg != 8'd0)};
            end
            OP_ENCODER:
            begin
                result_hit     = (s1_second_reg != ENC_CENTER);
                out_type_next  = EV_ENCODER;
                out_value_next = {7'd0, s1_second_reg} - {7'd0, ENC_CENTER};
            end
            OP_HALF:
            begin
                result_hit     = slot_complete;
                out_type_next  = EV_ABSOLUTE;
                out_value_next = {1'b0, slot_value};
            end
            default: result_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take_in)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_go)
            out_valid_next = result_hit;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_length_reg <= message_length;
            s1_status_reg <= status_byte;
            s1_first_reg  <= first_data;
            s1_second_reg <= second_data;
        end
        if (s1_go && result_hit)
        begin
            out_type_reg    <= out_type_next;
            out_control_reg <= out_control_next;
            out_value_reg   <= out_value_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_type     = out_type_reg;
    assign control_number = out_control_reg;
    assign event_value    = out_value_reg;

endmodule

// ===== sv/msm_checker.sv =====
// msm_checker: port-level assertions for the control surface mapper
// depends on msm_pkg; bound to midi_control_surface_mapper_core

module msm_checker
    import msm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         event_type,
    input logic [4:0]         control_number,
    input logic signed [14:0] event_value
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_type)
            && $stable(control_number) && $stable(event_value))
        else $error("result changed while stalled");

    // buttons carry 0 or 1 on the button ids
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_type == EV_BUTTON) |->
            (event_value == 15'sd0 || event_value == 15'sd1) && (control_number <= CTL_LOAD2))
        else $error("bad button event");

    // encoder deltas are nonzero and on jog or browse ids
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_type == EV_ENCODER) |-> (event_value != 15'sd0)
            && ((control_number >= CTL_SCRATCH && control_number < CTL_TEMPO)
                || control_number == CTL_BROWSE))
        else $error("bad encoder event");

    // absolute values are 14-bit and on slot ids
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_type == EV_ABSOLUTE) |-> !event_value[14]
            && control_number >= CTL_TEMPO && control_number <= CTL_XFADE
            && control_number != CTL_BROWSE)
        else $error("bad absolute event");

    // no event type beyond absolute
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_type == EV_BUTTON || event_type == EV_ENCODER
            || event_type == EV_ABSOLUTE))
        else $error("bad event type");

endmodule

bind midi_control_surface_mapper_core msm_checker u_msm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_type     (event_type),
    .control_number (control_number),
    .event_value    (event_value)
);

// ===== tb/sv/tb_midi_control_surface_mapper_core.sv =====
// tb_midi_control_surface_mapper_core: self-checking testbench for the control surface mapper
// predicts every button, encoder and 14-bit slot event and checks each output transfer
// depends on msm_pkg and midi_control_surface_mapper_core

module tb_midi_control_surface_mapper_core;
    timeunit 1ns;
    timeprecision 1ps;

    import msm_pkg::*;

    localparam int CycleLimit = 1000000;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         ctl;
        logic signed [14:0] val;
    } surface_event_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         message_length = 2'd0;
    logic [7:0]         status_byte = 8'd0;
    logic [7:0]         first_data = 8'd0;
    logic [7:0]         second_data = 8'd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         event_type;
    logic [4:0]         control_number;
    logic signed [14:0] event_value;

    surface_event_t pending_events[$];
    logic [6:0]     msb_store[SlotCount];
    logic [6:0]     lsb_store[SlotCount];
    bit             msb_seen[SlotCount];
    bit             lsb_seen[SlotCount];

    int error_count = 0;
    int cycle_count = 0;
    int hold_cycles = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;

    midi_control_surface_mapper_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .message_length (message_length),
        .status_byte    (status_byte),
        .first_data     (first_data),
        .second_data    (second_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_type     (event_type),
        .control_number (control_number),
        .event_value    (event_value)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("tb_midi_control_surface_mapper_core: errors");
            $finish;
        end
    end

    // slot mirror and expected event stream

    function automatic void expect_button(input logic [4:0] ctl, input logic [7:0] vel);
        surface_event_t e;
        e.kind = EV_BUTTON;
        e.ctl  = ctl;
        e.val  = (vel != 8'd0) ? 15'sd1 : 15'sd0;
        pending_events.push_back(e);
    endfunction

    function automatic void expect_delta(input logic [4:0] ctl, input logic [7:0] raw);
        surface_event_t e;
        if (raw == ENC_CENTER)
            return;
        e.kind = EV_ENCODER;
        e.ctl  = ctl;
        e.val  = {7'd0, raw} - 15'd64;
        pending_events.push_back(e);
    endfunction

    function automatic void update_slot(input int slot, input bit high,
                                        input logic [7:0] raw, input logic [4:0] ctl);
        surface_event_t e;
        if (high)
        begin
            msb_store[slot] = raw[6:0];
            msb_seen[slot]  = 1'b1;
        end
        else
        begin
            lsb_store[slot] = raw[6:0];
            lsb_seen[slot]  = 1'b1;
        end
        if (!(msb_seen[slot] && lsb_seen[slot]))
            return;
        e.kind = EV_ABSOLUTE;
        e.ctl  = ctl;
        e.val  = {1'b0, msb_store[slot], lsb_store[slot]};
        pending_events.push_back(e);
    endfunction

    function automatic void map_message(input logic [1:0] len, input logic [7:0] st,
                                        input logic [7:0] d1, input logic [7:0] d2);
        logic [4:0] dk;
        int         sd;
        dk = {4'd0, st[0]};
        sd = int'(st[0]);
        if (len != FULL_LENGTH)
            return;
        case (st)
            ST_NOTE_DECK1, ST_NOTE_DECK2:
                case (d1)
                    NOTE_PLAY:     expect_button(CTL_PLAY + dk, d2);
                    NOTE_CUE:      expect_button(CTL_CUE + dk, d2);
                    NOTE_JOGTOUCH: expect_button(CTL_JOGTOUCH + dk, d2);
                    NOTE_PFL:      expect_button(CTL_PFL + dk, d2);
                    default: ;
                endcase
            ST_NOTE_GLOB:
                case (d1)
                    NOTE_LOAD1: expect_button(CTL_LOAD1, d2);
                    NOTE_LOAD2: expect_button(CTL_LOAD2, d2);
                    default: ;
                endcase
            ST_CC_DECK1, ST_CC_DECK2:
                case (d1)
                    CC_JOG_SCRATCH:          expect_delta(CTL_SCRATCH + dk, d2);
                    CC_JOG_BEND, CC_SIDE_BEND: expect_delta(CTL_BEND + dk, d2);
                    CC_TEMPO_MSB: update_slot(int'(SLOT_TEMPO) + sd, 1'b1, d2, CTL_TEMPO + dk);
                    CC_TEMPO_LSB: update_slot(int'(SLOT_TEMPO) + sd, 1'b0, d2, CTL_TEMPO + dk);
                    CC_VOL_MSB:   update_slot(int'(SLOT_VOLUME) + sd, 1'b1, d2, CTL_VOLUME + dk);
                    CC_VOL_LSB:   update_slot(int'(SLOT_VOLUME) + sd, 1'b0, d2, CTL_VOLUME + dk);
                    default: ;
                endcase
            ST_CC_MASTER:
                case (d1)
                    CC_BROWSE:    expect_delta(CTL_BROWSE, d2);
                    CC_XFADE_MSB: update_slot(int'(SLOT_XFADE), 1'b1, d2, CTL_XFADE);
                    CC_XFADE_LSB: update_slot(int'(SLOT_XFADE), 1'b0, d2, CTL_XFADE);
                    default: ;
                endcase
            default: ;
        endcase
    endfunction

    // output transfer checker

    always @(posedge clk)
    begin
        surface_event_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_events.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected event type %0d ctl %0d value %0d", $time,
                         event_type, control_number, event_value);
            end
            else
            begin
                e = pending_events.pop_front();
                if (event_type !== e.kind)
                begin
                    error_count++;
                    $display("%0t: event_type expected %0d actual %0d", $time,
                             e.kind, event_type);
                end
                if (control_number !== e.ctl)
                begin
                    error_count++;
                    $display("%0t: control_number expected %0d actual %0d", $time,
                             e.ctl, control_number);
                end
                if (event_value !== e.val)
                begin
                    error_count++;
                    $display("%0t: event_value expected %0d actual %0d", $time,
                             e.val, event_value);
                end
            end
        end
    end

    function automatic int idle_len(input bit on);
        int r;
        if (!on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // receiver: random stalls plus long hold-off on request
    initial
    begin
        int rx_wait;
        rx_wait = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else if (rx_wait > 0)
            begin
                out_ready <= 1'b0;
                rx_wait--;
            end
            else
            begin
                out_ready <= 1'b1;
                rx_wait = idle_len(rx_idle_on);
            end
        end
    end

    // called right after a rising edge; returns after the accepting edge and any idle gap
    task automatic send_msg(input logic [1:0] len, input logic [7:0] st,
                            input logic [7:0] d1, input logic [7:0] d2);
        int gap;
        in_valid       <= 1'b1;
        message_length <= len;
        status_byte    <= st;
        first_data     <= d1;
        second_data    <= d2;
        do
            @(posedge clk);
        while (!in_ready);
        map_message(len, st, d1, d2);
        gap = idle_len(tx_idle_on);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        while (pending_events.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return ENC_CENTER;
            2: return 8'h7F;
            3: return 8'h80;
            4: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void pick_mapped(output logic [7:0] st, output logic [7:0] d1);
        logic [7:0] deck_note;
        logic [7:0] deck_cc;
        deck_note = ($urandom_range(0, 1) == 0) ? ST_NOTE_DECK1 : ST_NOTE_DECK2;
        deck_cc   = ($urandom_range(0, 1) == 0) ? ST_CC_DECK1 : ST_CC_DECK2;
        case ($urandom_range(0, 5))
            0:
            begin
                st = deck_note;
                case ($urandom_range(0, 3))
                    0: d1 = NOTE_PLAY;
                    1: d1 = NOTE_CUE;
                    2: d1 = NOTE_JOGTOUCH;
                    default: d1 = NOTE_PFL;
                endcase
            end
            1:
            begin
                st = ST_NOTE_GLOB;
                d1 = ($urandom_range(0, 1) == 0) ? NOTE_LOAD1 : NOTE_LOAD2;
            end
            2, 3:
            begin
                st = deck_cc;
                case ($urandom_range(0, 6))
                    0: d1 = CC_JOG_SCRATCH;
                    1: d1 = CC_JOG_BEND;
                    2: d1 = CC_SIDE_BEND;
                    3: d1 = CC_TEMPO_MSB;
                    4: d1 = CC_TEMPO_LSB;
                    5: d1 = CC_VOL_MSB;
                    default: d1 = CC_VOL_LSB;
                endcase
            end
            default:
            begin
                st = ST_CC_MASTER;
                case ($urandom_range(0, 2))
                    0: d1 = CC_BROWSE;
                    1: d1 = CC_XFADE_MSB;
                    default: d1 = CC_XFADE_LSB;
                endcase
            end
        endcase
    endfunction

    task automatic test_short_messages();
        send_msg(2'd0, ST_NOTE_DECK1, NOTE_PLAY, 8'h7F);
        send_msg(2'd1, ST_CC_DECK1, CC_TEMPO_MSB, 8'h7F);
        send_msg(2'd2, ST_CC_DECK1, CC_TEMPO_LSB, 8'h55);
    endtask

    task automatic test_buttons();
        send_msg(FULL_LENGTH, ST_NOTE_DECK1, NOTE_PLAY, 8'h80);
        send_msg(FULL_LENGTH, ST_NOTE_DECK2, NOTE_CUE, 8'h00);
        send_msg(FULL_LENGTH, ST_NOTE_DECK1, NOTE_JOGTOUCH, 8'hFF);
        send_msg(FULL_LENGTH, ST_NOTE_DECK2, NOTE_PFL, 8'h01);
        send_msg(FULL_LENGTH, ST_NOTE_GLOB, NOTE_LOAD1, 8'h7F);
        send_msg(FULL_LENGTH, ST_NOTE_GLOB, NOTE_LOAD2, 8'h00);
    endtask

    task automatic test_encoders();
        send_msg(FULL_LENGTH, ST_CC_DECK1, CC_JOG_SCRATCH, 8'h00);
        send_msg(FULL_LENGTH, ST_CC_DECK2, CC_JOG_BEND, 8'hFF);
        send_msg(FULL_LENGTH, ST_CC_DECK1, CC_SIDE_BEND, 8'd65);
        send_msg(FULL_LENGTH, ST_CC_MASTER, CC_BROWSE, ENC_CENTER);
        send_msg(FULL_LENGTH, ST_CC_MASTER, CC_BROWSE, 8'd63);
    endtask

    task automatic test_slots();
        // a completed tempo slot reports, half-filled slots stay silent, wide data keeps only 7 bits
        send_msg(FULL_LENGTH, ST_CC_DECK1, CC_TEMPO_MSB, 8'hFF);
        send_msg(FULL_LENGTH, ST_CC_DECK1, CC_TEMPO_LSB, 8'h7F);
        send_msg(FULL_LENGTH, ST_CC_MASTER, CC_XFADE_LSB, 8'h00);
        send_msg(FULL_LENGTH, ST_CC_DECK2, CC_VOL_MSB, 8'h80);
    endtask

    task automatic test_unmapped();
        send_msg(FULL_LENGTH, 8'h80, NOTE_PLAY, 8'h7F);
        send_msg(FULL_LENGTH, ST_NOTE_DECK1, 8'h00, 8'hFF);
        send_msg(FULL_LENGTH, ST_CC_MASTER, 8'h00, 8'h7F);
        send_msg(FULL_LENGTH, 8'hFF, 8'hFF, 8'hFF);
    endtask

    task automatic test_backpressure();
        tx_idle_on  = 1'b0;
        hold_cycles = 150;
        repeat (40)
            send_msg(FULL_LENGTH, ST_NOTE_DECK2, NOTE_PLAY, 8'($urandom_range(0, 255)));
        in_valid <= 1'b0;
        wait_drain();
        @(posedge clk);
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic(input int count);
        logic [1:0] len;
        logic [7:0] st;
        logic [7:0] d1;
        logic [7:0] d2;
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                pick_mapped(st, d1);
                len = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 2)) : FULL_LENGTH;
                d2  = rand_value();
            end
            else
            begin
                pick_mapped(st, d1);
                if ($urandom_range(0, 1) == 0)
                    st = 8'($urandom_range(0, 255));
                len = 2'($urandom_range(0, 3));
                d1  = 8'($urandom_range(0, 255));
                d2  = 8'($urandom_range(0, 255));
            end
            send_msg(len, st, d1, d2);
        end
    endtask

    initial
    begin
        for (int s = 0; s < SlotCount; s++)
        begin
            msb_store[s] = 7'd0;
            lsb_store[s] = 7'd0;
            msb_seen[s]  = 1'b0;
            lsb_seen[s]  = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_messages();
        test_buttons();
        test_encoders();
        test_slots();
        test_unmapped();
        test_backpressure();
        test_random_traffic(1490);

        in_valid <= 1'b0;
        wait_drain();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("tb_midi_control_surface_mapper_core: clean");
        else
            $display("tb_midi_control_surface_mapper_core: errors");
        $finish;
    end

endmodule

// ===== midi_control_surface_mapper_core.f =====
sv/msm_pkg.sv
sv/msm_decode.sv
sv/msm_slots.sv
sv/midi_control_surface_mapper_core.sv
sv/msm_checker.sv
tb/sv/tb_midi_control_surface_mapper_core.sv
